FILE: hdl/mad_pkg.sv
`default_nettype none
package mad_pkg;

   localparam int DEFAULT_SAMPLE_WIDTH = 16;
   localparam int DEFAULT_MAX_CHANNELS = 8;

   localparam int FACTOR_WIDTH = 8;
   localparam int COUNT_WIDTH  = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = 8'd1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_RESET  = 4'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECIMATION_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHANNEL_COUNT     = 2'd1;

   localparam int QUEUE_DEPTH = 2;

   // Width of a channel number for a given channel capacity.
   function automatic int ch_width(input int max_channels);
      ch_width = (max_channels > 1) ? $clog2(max_channels) : 1;
   endfunction

   // A group sum never exceeds the factor times the largest sample.
   function automatic int sum_width(input int sample_width);
      sum_width = sample_width + FACTOR_WIDTH;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/mad_queue.sv
`default_nettype none
module mad_queue #(
   parameter int DATA_W = 27
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output logic [DATA_W-1:0]      pop_data
);

   localparam int DEPTH = mad_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mad_front.sv
`default_nettype none
module mad_front #(
   parameter int SAMPLE_WIDTH = mad_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int MAX_CHANNELS = mad_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in,
   input  wire logic                                    req_buffer_end,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [mad_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [mad_pkg::CSR_DATA_WIDTH-1:0]      csr_data,
   output logic [mad_pkg::FACTOR_WIDTH-1:0]             factor,
   output logic                                         push,
   output logic [mad_pkg::sum_width(SAMPLE_WIDTH)
                 + mad_pkg::ch_width(MAX_CHANNELS)-1:0] push_data,
   input  wire logic                                    full
);

   localparam int CH_W  = mad_pkg::ch_width(MAX_CHANNELS);
   localparam int SUM_W = mad_pkg::sum_width(SAMPLE_WIDTH);
   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int FW    = mad_pkg::FACTOR_WIDTH;

   logic [FW-1:0]                    factor_ff, factor_in;
   logic [mad_pkg::COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [CH_W-1:0]                  ch_ff, ch_in;
   logic [FW-1:0]                    group_ff, group_in;
   logic signed [SUM_W-1:0]          sum_ff [MAX_CHANNELS];

   logic [CNT_W-1:0]        chans;
   logic                    accept;
   logic                    last_ch;
   logic                    last_group;
   logic signed [SUM_W-1:0] sample_ext;
   logic signed [SUM_W-1:0] new_sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = full;
   assign csr_ready = 1'b1;

   always_comb begin
      if (factor_ff == '0) begin
         factor = FW'(1);
      end else begin
         factor = factor_ff;
      end
      if (count_ff == '0) begin
         chans = CNT_W'(1);
      end else if (32'(count_ff) > MAX_CHANNELS) begin
         chans = CNT_W'(MAX_CHANNELS);
      end else begin
         chans = CNT_W'(count_ff);
      end
   end

   assign last_ch    = (({1'b0, ch_ff} + 1'b1) == (CH_W + 1)'(chans));
   assign last_group = (group_ff == factor - 1'b1);
   assign sample_ext = {{(SUM_W - SAMPLE_WIDTH){req_sample_in[SAMPLE_WIDTH-1]}}, req_sample_in};
   // The first frame of a group loads the sum instead of adding to it.
   assign new_sum    = ((group_ff == '0) ? '0 : sum_ff[ch_ff]) + sample_ext;

   assign push      = accept && last_group;
   assign push_data = {new_sum, ch_ff};

   always_comb begin
      factor_in = factor_ff;
      count_in  = count_ff;
      ch_in     = ch_ff;
      group_in  = group_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mad_pkg::REG_DECIMATION_FACTOR: begin
               factor_in = csr_data[FW-1:0];
               ch_in     = '0;
               group_in  = '0;
            end
            mad_pkg::REG_CHANNEL_COUNT: begin
               count_in = csr_data[mad_pkg::COUNT_WIDTH-1:0];
               ch_in    = '0;
               group_in = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (last_ch) begin
            ch_in    = '0;
            group_in = last_group ? '0 : group_ff + 1'b1;
         end else begin
            ch_in = ch_ff + 1'b1;
         end
         // Drop any partial group at the end of a buffer.
         if (req_buffer_end) begin
            ch_in    = '0;
            group_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= mad_pkg::FACTOR_RESET;
         count_ff  <= mad_pkg::COUNT_RESET;
         ch_ff     <= '0;
         group_ff  <= '0;
      end else begin
         factor_ff <= factor_in;
         count_ff  <= count_in;
         ch_ff     <= ch_in;
         group_ff  <= group_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff[ch_ff] <= new_sum;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/mad_back.sv
`default_nettype none
module mad_back #(
   parameter int SAMPLE_WIDTH = mad_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int MAX_CHANNELS = mad_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic [mad_pkg::FACTOR_WIDTH-1:0]        factor,
   input  wire logic                                    not_empty,
   input  wire logic [mad_pkg::sum_width(SAMPLE_WIDTH)
                      + mad_pkg::ch_width(MAX_CHANNELS)-1:0] pop_data,
   output logic                                         pop,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]               rsp_mean_out,
   output logic [mad_pkg::ch_width(MAX_CHANNELS)-1:0]   rsp_channel_index
);

   localparam int CH_W  = mad_pkg::ch_width(MAX_CHANNELS);
   localparam int SUM_W = mad_pkg::sum_width(SAMPLE_WIDTH);
   localparam int FW    = mad_pkg::FACTOR_WIDTH;
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      DONE
   } state_type;

   state_type               state_ff;
   logic                    neg_ff;
   logic [FW-1:0]           rem_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [CH_W-1:0]         ch_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_mean_ff;
   logic [CH_W-1:0]         rsp_ch_ff;

   logic signed [SUM_W-1:0] pop_sum;
   logic [CH_W-1:0]         pop_ch;
   logic [SUM_W-1:0]        pop_mag;
   logic [FW:0]             trial;
   logic [FW:0]             diff;
   logic [SUM_W-1:0]        quo_signed;
   logic                    out_free;

   assign pop_sum = pop_data[SUM_W+CH_W-1:CH_W];
   assign pop_ch  = pop_data[CH_W-1:0];
   assign pop_mag = pop_sum[SUM_W-1] ? SUM_W'(-pop_sum) : SUM_W'(pop_sum);

   // One restoring step: shift in the next dividend bit and try the factor.
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, factor};

   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign pop        = (state_ff == IDLE) && not_empty;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean_out      = rsp_mean_ff;
   assign rsp_channel_index = rsp_ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (not_empty) begin
                  neg_ff   <= pop_sum[SUM_W-1];
                  quo_ff   <= pop_mag;
                  rem_ff   <= '0;
                  ch_ff    <= pop_ch;
                  step_ff  <= '0;
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               if (!diff[FW]) begin
                  rem_ff <= diff[FW-1:0];
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_ff <= trial[FW-1:0];
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               // Hold the quotient until the output register frees up.
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mean_ff  <= quo_signed[SAMPLE_WIDTH-1:0];
                  rsp_ch_ff    <= ch_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: hdl/multichannel_average_decimator.sv
`default_nettype none
// Boxcar averaging decimator for interleaved multichannel samples. Each
// transfer on the req_ channel carries one sample of the next channel in
// the frame; after decimation_factor frames a channel's group is complete
// and its mean (sum divided by the factor, truncated toward zero) leaves
// on the rsp_ channel with its channel number. req_buffer_end drops any
// partial group and restarts at channel 0, frame 0; a write to the factor
// or channel count register does the same. The front accepts one sample
// per cycle while req_stall is low and updates the per-channel sums;
// completed sums wait in a two-entry queue for a restoring divider that
// retires one quotient bit per cycle and takes a new sum only once it is
// back in IDLE. While the queue is full, req_stall holds every sample,
// also those that complete no group; with a factor of 1 the divider sets
// the sustained rate. Write registers only while the block is idle;
// csr_ready is always high.
module multichannel_average_decimator #(
   parameter int SAMPLE_WIDTH = mad_pkg::DEFAULT_SAMPLE_WIDTH,
   parameter int MAX_CHANNELS = mad_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_sample_in,
   input  wire logic                                  req_buffer_end,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_mean_out,
   output logic [mad_pkg::ch_width(MAX_CHANNELS)-1:0] rsp_channel_index,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mad_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [mad_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam int CH_W   = mad_pkg::ch_width(MAX_CHANNELS);
   localparam int SUM_W  = mad_pkg::sum_width(SAMPLE_WIDTH);
   localparam int DATA_W = SUM_W + CH_W;

   logic [mad_pkg::FACTOR_WIDTH-1:0] factor;
   logic                             push;
   logic [DATA_W-1:0]                push_data;
   logic                             full;
   logic                             pop;
   logic                             not_empty;
   logic [DATA_W-1:0]                pop_data;

   mad_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .req_buffer_end (req_buffer_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .factor         (factor),
      .push           (push),
      .push_data      (push_data),
      .full           (full)
   );

   mad_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   mad_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .factor            (factor),
      .not_empty         (not_empty),
      .pop_data          (pop_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mean_out      (rsp_mean_out),
      .rsp_channel_index (rsp_channel_index)
   );

endmodule
`default_nettype wire
